// ----- hw/rtl/rfb_pkg.sv -----
// ----------------------------------------------------------------------------
// rfb_pkg
// Shared types, constants and helpers for the rotating field boundary block.
// ----------------------------------------------------------------------------
package rfb_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int CW            = 34;   // CORDIC datapath width
  localparam int CFG_IDX_W     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_RATE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_AMPLITUDE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_PHASE     = 8'd2;

  localparam logic signed [CW-1:0] INV_GAIN_Q30 = 34'sd652032874;

  // quadrant codes
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // arctangent of 2^-i in 2^-32 turn
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'd536870912;  1:  r = 32'd316933406;  2:  r = 32'd167458907;
      3:  r = 32'd85004756;   4:  r = 32'd42667331;   5:  r = 32'd21354465;
      6:  r = 32'd10679838;   7:  r = 32'd5340245;    8:  r = 32'd2670163;
      9:  r = 32'd1335087;    10: r = 32'd667544;     11: r = 32'd333772;
      12: r = 32'd166886;     13: r = 32'd83443;      14: r = 32'd41722;
      15: r = 32'd20861;      16: r = 32'd10430;      17: r = 32'd5215;
      18: r = 32'd2608;       19: r = 32'd1304;       20: r = 32'd652;
      21: r = 32'd326;        22: r = 32'd163;        23: r = 32'd81;
      24: r = 32'd41;         25: r = 32'd20;         26: r = 32'd10;
      27: r = 32'd5;          28: r = 32'd3;          29: r = 32'd1;
      30: r = 32'd1;          default: r = 32'd0;
    endcase
    return r;
  endfunction

  // clamp a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647)       r = 32'sh7fffffff;
    else if (v < -68'sd2147483648) r = 32'sh80000000;
    else                           r = v[31:0];
    return r;
  endfunction

  // word delayed alongside the CORDIC pipe
  typedef struct packed {
    logic signed [34:0] en;
    logic signed [34:0] et;
    logic signed [31:0] ez;
    logic signed [31:0] bz;
    logic signed [31:0] phi;
    logic signed [31:0] psi;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
  } side_t;

endpackage

// ----- hw/rtl/rfb_in_if.sv -----
// ----------------------------------------------------------------------------
// rfb_in_if
// Input channel: one boundary face word.
// ----------------------------------------------------------------------------
interface rfb_in_if;
  logic               valid;
  logic               ready;
  logic        [31:0] sim_time;
  logic signed [31:0] e_x;
  logic signed [31:0] e_y;
  logic signed [31:0] e_z;
  logic signed [31:0] b_z;
  logic signed [31:0] elec_potential;
  logic signed [31:0] mag_potential;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;

  modport source (output valid, sim_time, e_x, e_y, e_z, b_z, elec_potential,
                  mag_potential, normal_x, normal_y, input ready);
  modport sink   (input valid, sim_time, e_x, e_y, e_z, b_z, elec_potential,
                  mag_potential, normal_x, normal_y, output ready);
endinterface

// ----- hw/rtl/rfb_out_if.sv -----
// ----------------------------------------------------------------------------
// rfb_out_if
// Result channel: eight ghost components.
// ----------------------------------------------------------------------------
interface rfb_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] ghost_e_x;
  logic signed [31:0] ghost_e_y;
  logic signed [31:0] ghost_e_z;
  logic signed [31:0] ghost_b_x;
  logic signed [31:0] ghost_b_y;
  logic signed [31:0] ghost_b_z;
  logic signed [31:0] ghost_elec_potential;
  logic signed [31:0] ghost_mag_potential;

  modport source (output valid, ghost_e_x, ghost_e_y, ghost_e_z, ghost_b_x,
                  ghost_b_y, ghost_b_z, ghost_elec_potential,
                  ghost_mag_potential, input ready);
  modport sink   (input valid, ghost_e_x, ghost_e_y, ghost_e_z, ghost_b_x,
                  ghost_b_y, ghost_b_z, ghost_elec_potential,
                  ghost_mag_potential, output ready);
endinterface

// ----- hw/rtl/rfb_cfg_if.sv -----
// ----------------------------------------------------------------------------
// rfb_cfg_if
// Configuration write channel: register index and data.
// ----------------------------------------------------------------------------
interface rfb_cfg_if;
  import rfb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/rotating_field_boundary_state.sv -----
// ----------------------------------------------------------------------------
// rotating_field_boundary_state
// Ghost state at one boundary face with a rotating magnetic field.
// ----------------------------------------------------------------------------
// Channels: in_chan takes one face word (time, interior fields, Q1.14 normal),
// out_chan gives the eight ghost components, cfg_chan writes angular_rate (0),
// field_amplitude (1) and start_phase (2); other indexes are ignored.
// cfg_chan is always ready; write it only while no face is in flight.
// Pipeline from accept to result: angle product, angle/normal split, the
// CORDIC stages, product, round and saturate. Throughput: one face per cycle
// while out_chan is not stalling, set by the fully pipelined CORDIC and
// multiplier stages.
// Reset clears all valid bits and the three registers to zero.
// Stall: the whole pipe holds while a result waits and out_chan.ready is low;
// in_chan.ready is low exactly then, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module rotating_field_boundary_state
  import rfb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  rfb_in_if.sink   in_chan,
  rfb_out_if.source out_chan,
  rfb_cfg_if.sink  cfg_chan
);

  logic        [31:0] rate_r;
  logic signed [31:0] amp_r;
  logic        [31:0] phase_r;
  logic adv;

  // register file
  assign cfg_chan.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= '0;
      amp_r   <= '0;
      phase_r <= '0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_ANGULAR_RATE:    rate_r  <= cfg_chan.data;
        REG_FIELD_AMPLITUDE: amp_r   <= cfg_chan.data;
        REG_START_PHASE:     phase_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  assign adv           = !out_chan.valid || out_chan.ready;
  assign in_chan.ready = adv;

  // stage 1: products
  logic               v1_r;
  logic        [63:0] ang_prod_r;
  logic signed [47:0] p_xx_r, p_yy_r, p_xy_r, p_yx_r;
  logic signed [31:0] ez1_r, bz1_r, phi1_r, psi1_r;
  logic signed [15:0] nx1_r, ny1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_chan.valid;
    if (adv) begin
      ang_prod_r <= 64'(rate_r) * 64'(in_chan.sim_time);
      p_xx_r <= 48'(in_chan.e_x) * 48'(in_chan.normal_x);
      p_yy_r <= 48'(in_chan.e_y) * 48'(in_chan.normal_y);
      p_xy_r <= 48'(in_chan.e_x) * 48'(in_chan.normal_y);
      p_yx_r <= 48'(in_chan.e_y) * 48'(in_chan.normal_x);
      ez1_r  <= in_chan.e_z;
      bz1_r  <= in_chan.b_z;
      phi1_r <= in_chan.elec_potential;
      psi1_r <= in_chan.mag_potential;
      nx1_r  <= in_chan.normal_x;
      ny1_r  <= in_chan.normal_y;
    end
  end

  // stage 2: angle split and normal/tangential rounding
  logic        [31:0] ang, ang_off, z_raw;
  logic [1:0]         quad;
  logic signed [48:0] en_sum, et_sum;
  side_t              side_nxt;
  logic               v2_r;
  logic signed [CW-1:0] z2_r;
  logic [1:0]         q2_r;
  side_t              side_r [CORDIC_STAGES+1];

  always_comb begin
    ang     = ang_prod_r[47:16] + phase_r;
    ang_off = ang + 32'h2000_0000;
    quad    = ang_off[31:30];
    z_raw   = ang - {quad, 30'd0};
    en_sum  = 49'(p_xx_r) + 49'(p_yy_r) + 49'sd8192;
    et_sum  = 49'(p_xy_r) - 49'(p_yx_r) + 49'sd8192;
    side_nxt.en  = 35'(en_sum >>> 14);
    side_nxt.et  = 35'(et_sum >>> 14);
    side_nxt.ez  = ez1_r;
    side_nxt.bz  = bz1_r;
    side_nxt.phi = phi1_r;
    side_nxt.psi = psi1_r;
    side_nxt.nx  = nx1_r;
    side_nxt.ny  = ny1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
    if (adv) begin
      z2_r      <= CW'(signed'(z_raw));
      q2_r      <= quad;
      side_r[0] <= side_nxt;
      for (int i = 1; i <= CORDIC_STAGES; i++) side_r[i] <= side_r[i-1];
    end
  end

  logic                 vc;
  logic signed [CW-1:0] cos_w, sin_w;

  rfb_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_valid(v2_r), .in_z(z2_r), .in_quad(q2_r),
    .out_valid(vc), .cos_o(cos_w), .sin_o(sin_w)
  );

  // stage 3: amplitude and rebuild products
  side_t              sc;
  logic               v3_r;
  logic signed [65:0] bx_p_r, by_p_r;
  logic signed [50:0] q_enx_r, q_ety_r, q_eny_r, q_etx_r;
  logic signed [31:0] ez3_r, bz3_r, phi3_r, psi3_r;

  assign sc = side_r[CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= vc;
    if (adv) begin
      bx_p_r  <= 66'(amp_r) * 66'(cos_w);
      by_p_r  <= 66'(amp_r) * 66'(sin_w);
      q_enx_r <= 51'(sc.en) * 51'(sc.nx);
      q_ety_r <= 51'(sc.et) * 51'(sc.ny);
      q_eny_r <= 51'(sc.en) * 51'(sc.ny);
      q_etx_r <= 51'(sc.et) * 51'(sc.nx);
      ez3_r   <= sc.ez;
      bz3_r   <= sc.bz;
      phi3_r  <= sc.phi;
      psi3_r  <= sc.psi;
    end
  end

  // stage 4: round, saturate, output register
  logic signed [51:0] gx_sum, gy_sum;
  logic signed [67:0] bx_rnd, by_rnd;
  logic               vo_r;
  logic signed [31:0] gex_r, gey_r, gez_r, gbx_r, gby_r, gbz_r, gphi_r, gpsi_r;

  always_comb begin
    gx_sum = 52'(q_enx_r) - 52'(q_ety_r) + 52'sd8192;
    gy_sum = 52'(q_eny_r) + 52'(q_etx_r) + 52'sd8192;
    bx_rnd = (68'(bx_p_r) + 68'sd536870912) >>> 30;
    by_rnd = (68'(by_p_r) + 68'sd536870912) >>> 30;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else if (adv) vo_r <= v3_r;
    if (adv) begin
      gex_r  <= sat32(68'(gx_sum >>> 14));
      gey_r  <= sat32(68'(gy_sum >>> 14));
      gez_r  <= sat32(-68'(ez3_r));
      gbx_r  <= sat32(bx_rnd);
      gby_r  <= sat32(by_rnd);
      gbz_r  <= bz3_r;
      gphi_r <= sat32(-68'(phi3_r));
      gpsi_r <= psi3_r;
    end
  end

  assign out_chan.valid                = vo_r;
  assign out_chan.ghost_e_x            = gex_r;
  assign out_chan.ghost_e_y            = gey_r;
  assign out_chan.ghost_e_z            = gez_r;
  assign out_chan.ghost_b_x            = gbx_r;
  assign out_chan.ghost_b_y            = gby_r;
  assign out_chan.ghost_b_z            = gbz_r;
  assign out_chan.ghost_elec_potential = gphi_r;
  assign out_chan.ghost_mag_potential  = gpsi_r;

  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready == (!vo_r || out_chan.ready)) else $error("ready mismatch");
  a_rst: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !vo_r) else $error("result valid after reset");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(v1_r) && $stable(v2_r) && $stable(v3_r)))
    else $error("pipe moved while held");

endmodule

// ----- hw/rtl/rfb_cordic.sv -----
// ----------------------------------------------------------------------------
// rfb_cordic
// Pipelined rotation CORDIC, one stage per register, then quadrant turn.
// ----------------------------------------------------------------------------
module rfb_cordic
  import rfb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] in_z,
  input  logic [1:0]           in_quad,
  output logic                 out_valid,
  output logic signed [CW-1:0] cos_o,
  output logic signed [CW-1:0] sin_o
);

  logic signed [CW-1:0] x_r [CORDIC_STAGES];
  logic signed [CW-1:0] y_r [CORDIC_STAGES];
  logic signed [CW-1:0] z_r [CORDIC_STAGES];
  logic [1:0]           q_r [CORDIC_STAGES];
  logic [CORDIC_STAGES-1:0] v_r;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [CW-1:0] xi, yi, zi, at;
    logic [1:0]           qi;
    logic                 vi;
    if (i == 0) begin : g_first
      assign xi = INV_GAIN_Q30;
      assign yi = '0;
      assign zi = in_z;
      assign qi = in_quad;
      assign vi = in_valid;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign qi = q_r[i-1];
      assign vi = v_r[i-1];
    end
    assign at = CW'(atan_turn(i));

    // rotate toward zero residual angle
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (adv) begin
        v_r[i] <= vi;
      end
      if (adv) begin
        q_r[i] <= qi;
        if (!zi[CW-1]) begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
          z_r[i] <= zi - at;
        end else begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
          z_r[i] <= zi + at;
        end
      end
    end
  end

  // turn the pair by whole quarter turns
  always_comb begin
    unique case (q_r[CORDIC_STAGES-1])
      QUAD_0: begin cos_o = x_r[CORDIC_STAGES-1];  sin_o = y_r[CORDIC_STAGES-1];  end
      QUAD_1: begin cos_o = -y_r[CORDIC_STAGES-1]; sin_o = x_r[CORDIC_STAGES-1];  end
      QUAD_2: begin cos_o = -x_r[CORDIC_STAGES-1]; sin_o = -y_r[CORDIC_STAGES-1]; end
      default: begin cos_o = y_r[CORDIC_STAGES-1]; sin_o = -x_r[CORDIC_STAGES-1]; end
    endcase
  end

  assign out_valid = v_r[CORDIC_STAGES-1];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r)) else $error("cordic valids moved while held");

endmodule

// ----- bench/rfb_tb_if.sv -----
// ----------------------------------------------------------------------------
// rfb_tb_if
// Bench-side notes: channel interfaces come from the RTL files; this file
// holds the face and ghost word types that the bench queues and checks.
// ----------------------------------------------------------------------------
package rfb_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        [31:0] sim_time;
    logic signed [31:0] e_x, e_y, e_z, b_z, phi, psi;
    logic signed [15:0] nx, ny;
  } face_t;

  typedef struct {
    logic signed [31:0] gex, gey, gez, gbx, gby, gbz, gphi, gpsi;
  } ghost_t;
endpackage

// ----- bench/rotating_field_boundary_state_tb.sv -----
// ----------------------------------------------------------------------------
// rotating_field_boundary_state_tb
// Drives boundary face words with bursty input and a stalling receiver,
// predicts the eight ghost components and checks each result word in order.
// ----------------------------------------------------------------------------
module rotating_field_boundary_state_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rfb_pkg::*;
  import rfb_tb_pkg::*;

  localparam int LATENCY = CORDIC_STAGES + 4;
  localparam longint LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rfb_in_if  in_chan();
  rfb_out_if out_chan();
  rfb_cfg_if cfg_chan();

  rotating_field_boundary_state dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor copy of the registers
  logic [31:0] rate_q, amp_q, phase_q;

  face_t  pending_faces[$];
  ghost_t expected_ghosts[$];
  int     fails = 0;
  longint cycles = 0;
  bit     hold_rx = 1'b0;
  int     burst_left = 0;
  int     gap_left = 0;

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rshift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // sine and cosine of an angle in 2^-32 turn, Q1.30
  function automatic void rotate_angle(input logic [31:0] a, output longint c,
                                       output longint s);
    longint atans[32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0};
    logic [32:0] sum;
    logic [1:0]  quad;
    logic [31:0] res;
    longint x, y, z, dx, dy;
    int n;
    sum = {1'b0, a} + 33'h20000000;
    quad = sum[31:30];
    res = a - {quad, 30'd0};
    z = longint'($signed(res));
    x = 652032874;
    y = 0;
    n = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    for (int i = 0; i < n; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atans[i];
      end else begin
        x += dx; y -= dy; z += atans[i];
      end
    end
    case (quad)
      QUAD_0: begin c = x;  s = y;  end
      QUAD_1: begin c = -y; s = x;  end
      QUAD_2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic ghost_t ghost_of(face_t f);
    ghost_t g;
    longint ex, ey, nx, ny, en, et, amp, c, s;
    logic [63:0] prod;
    logic [31:0] ang;
    ex = f.e_x; ey = f.e_y; nx = f.nx; ny = f.ny;
    en = rshift(ex * nx + ey * ny, 14);
    et = rshift(ex * ny - ey * nx, 14);
    prod = {32'd0, rate_q} * {32'd0, f.sim_time};
    ang = prod[47:16] + phase_q;
    rotate_angle(ang, c, s);
    amp = longint'($signed(amp_q));
    g.gex  = clamp32(rshift(en * nx - et * ny, 14));
    g.gey  = clamp32(rshift(en * ny + et * nx, 14));
    g.gez  = clamp32(-longint'(f.e_z));
    g.gbx  = clamp32(rshift(amp * c, 30));
    g.gby  = clamp32(rshift(amp * s, 30));
    g.gbz  = f.b_z;
    g.gphi = clamp32(-longint'(f.phi));
    g.gpsi = f.psi;
    return g;
  endfunction

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return $urandom_range(0, 200) - 100;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_normal();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'h8000;
      3: return 16'h7fff;
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic face_t rand_face();
    face_t f;
    f.sim_time = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4096) : $urandom;
    f.e_x = rand_field(); f.e_y = rand_field(); f.e_z = rand_field();
    f.b_z = rand_field(); f.phi = rand_field(); f.psi = rand_field();
    f.nx = rand_normal(); f.ny = rand_normal();
    return f;
  endfunction

  task automatic push_face(face_t f);
    pending_faces.push_back(f);
  endtask

  // write one register; predictor updates at the handshake
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    cfg_chan.valid <= 1'b1;
    do @(posedge clk); while (!cfg_chan.ready);
    case (idx)
      REG_ANGULAR_RATE:    rate_q  = val;
      REG_FIELD_AMPLITUDE: amp_q   = val;
      REG_START_PHASE:     phase_q = val;
      default: ;
    endcase
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_faces.size() != 0 || expected_ghosts.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.sim_time = '0; in_chan.e_x = '0; in_chan.e_y = '0; in_chan.e_z = '0;
    in_chan.b_z = '0; in_chan.elec_potential = '0; in_chan.mag_potential = '0;
    in_chan.normal_x = '0; in_chan.normal_y = '0;
    cfg_chan.valid = 1'b0; cfg_chan.index = '0; cfg_chan.data = '0;
    out_chan.ready = 1'b0;
  end

  // stimulus phases
  initial begin
    face_t f;
    logic [31:0] rates[4]  = '{32'd0, 32'hffffffff, 32'd65536, 32'h12345678};
    logic [31:0] amps[4]   = '{32'h00010000, 32'h7fffffff, 32'h80000000, 32'hfff80000};
    logic [31:0] phases[4] = '{32'd0, 32'hffffffff, 32'h40000000, 32'h20000000};
    rate_q = '0; amp_q = '0; phase_q = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // reset state: amplitude zero
    push_face(rand_face());
    drain();
    write_reg(REG_ANGULAR_RATE, 32'h00010000);
    write_reg(REG_FIELD_AMPLITUDE, 32'h00010000);
    write_reg(REG_START_PHASE, 32'd0);
    write_reg(8'hff, 32'hdeadbeef);
    // directed: extremes, axis normals, quarter-turn boundaries
    for (int i = 0; i < 20; i++) begin
      f = rand_face();
      case (i)
        0: begin
          f.e_x = 32'h7fffffff; f.e_y = 32'h7fffffff; f.nx = 16'sd16384; f.ny = 16'sd16384;
        end
        1: begin f.e_x = 32'h80000000; f.e_y = 32'h7fffffff; f.nx = 16'h8000; f.ny = 16'h7fff; end
        2: begin f.e_z = 32'h80000000; f.phi = 32'h80000000; end
        3: begin f.e_z = 32'h7fffffff; f.phi = 32'h7fffffff; f.b_z = 32'h80000000; end
        4: begin f.nx = 16'sd0; f.ny = 16'sd0; end
        5: begin f.nx = 16'sd16384; f.ny = 16'sd0; f.e_x = 1; f.e_y = -1; end
        6: f.sim_time = 32'h20000000 >> 0;
        7: f.sim_time = 32'he0000000;
        8: f.sim_time = 32'h1fffffff;
        9: f.sim_time = 32'hffffffff;
        10: f.sim_time = 32'd0;
        11: f.sim_time = 32'h40000000;
        12: f.sim_time = 32'h60000000;
        default: ;
      endcase
      push_face(f);
    end
    drain();
    // random phases across register settings, extremes among them
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_ANGULAR_RATE, p < 4 ? rates[p] : $urandom);
      write_reg(REG_FIELD_AMPLITUDE, p < 4 ? amps[p] : $urandom);
      write_reg(REG_START_PHASE, p < 4 ? phases[p] : $urandom);
      for (int i = 0; i < 125; i++) push_face(rand_face());
      drain();
    end
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // driver: bursts with gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        expected_ghosts.push_back(ghost_of(pending_faces.pop_front()));
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_chan.valid <= 1'b0;
        end else if (pending_faces.size() > (in_chan.valid && in_chan.ready ? 0 : 0)
                     && pending_faces.size() != 0) begin
          in_chan.valid          <= 1'b1;
          in_chan.sim_time       <= pending_faces[0].sim_time;
          in_chan.e_x            <= pending_faces[0].e_x;
          in_chan.e_y            <= pending_faces[0].e_y;
          in_chan.e_z            <= pending_faces[0].e_z;
          in_chan.b_z            <= pending_faces[0].b_z;
          in_chan.elec_potential <= pending_faces[0].phi;
          in_chan.mag_potential  <= pending_faces[0].psi;
          in_chan.normal_x       <= pending_faces[0].nx;
          in_chan.normal_y       <= pending_faces[0].ny;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off once, during a full random phase, so the pipe
  // fills and stalls the input
  initial begin
    wait (rst_n);
    repeat (200) @(posedge clk);
    while (pending_faces.size() < 100) @(posedge clk);
    hold_rx = 1'b1;
    repeat (200) @(posedge clk);
    hold_rx = 1'b0;
  end

  // monitor: stall pattern and result checks
  always @(posedge clk) begin
    ghost_t g;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_ghosts.size() == 0) begin
          $error("result word with none expected");
          fails++;
        end else begin
          g = expected_ghosts.pop_front();
          if (out_chan.ghost_e_x !== g.gex) begin
            $error("ghost_e_x exp %0d got %0d", g.gex, out_chan.ghost_e_x); fails++;
          end
          if (out_chan.ghost_e_y !== g.gey) begin
            $error("ghost_e_y exp %0d got %0d", g.gey, out_chan.ghost_e_y); fails++;
          end
          if (out_chan.ghost_e_z !== g.gez) begin
            $error("ghost_e_z exp %0d got %0d", g.gez, out_chan.ghost_e_z); fails++;
          end
          if (out_chan.ghost_b_x !== g.gbx) begin
            $error("ghost_b_x exp %0d got %0d", g.gbx, out_chan.ghost_b_x); fails++;
          end
          if (out_chan.ghost_b_y !== g.gby) begin
            $error("ghost_b_y exp %0d got %0d", g.gby, out_chan.ghost_b_y); fails++;
          end
          if (out_chan.ghost_b_z !== g.gbz) begin
            $error("ghost_b_z exp %0d got %0d", g.gbz, out_chan.ghost_b_z); fails++;
          end
          if (out_chan.ghost_elec_potential !== g.gphi) begin
            $error("ghost_elec_potential exp %0d got %0d", g.gphi,
                   out_chan.ghost_elec_potential); fails++;
          end
          if (out_chan.ghost_mag_potential !== g.gpsi) begin
            $error("ghost_mag_potential exp %0d got %0d", g.gpsi,
                   out_chan.ghost_mag_potential); fails++;
          end
        end
      end
      // stall on a pattern: quiet stretches, then random
      if (hold_rx) out_chan.ready <= 1'b0;
      else if (cycles[9:8] == 2'd0) out_chan.ready <= 1'b1;
      else out_chan.ready <= ($urandom_range(0, 3) != 0);
    end
  end

endmodule
